FILE: rtl/dqmb_pkg.sv
// ----------------------------------------------------------------------------
// dqmb_pkg
// shared constants, command type and sequencer states of the query builder
// ----------------------------------------------------------------------------
`default_nettype none

package dqmb_pkg;

   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 16;
   localparam int MAX_LABEL   = 32;
   localparam int FILL_W      = $clog2(MAX_LABEL + 1);
   localparam int IDX_W       = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
   localparam int CNT_W       = 9;
   localparam int STEP_W      = 4;
   localparam int CSR_INDEX_W = 1;

   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int QPTR_W          = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
   localparam int QCNT_W          = $clog2(CMD_QUEUE_DEPTH + 1);

   localparam logic [BYTE_W-1:0] DOT_CHAR   = 8'd46;
   localparam logic [CNT_W-1:0]  CNT_MAX    = 9'd511;
   localparam logic [WORD_W-1:0] QUERY_ID_RESET   = 16'h0404;
   localparam logic [WORD_W-1:0] QUERY_TYPE_RESET = 16'h0001;
   localparam logic [WORD_W-1:0] FLAGS_RD   = 16'h0100;
   localparam logic [WORD_W-1:0] QDCOUNT    = 16'h0001;
   localparam logic [WORD_W-1:0] CLASS_IN   = 16'h0001;
   localparam logic [BYTE_W-1:0] ZERO_BYTE  = 8'h00;

   localparam logic [CSR_INDEX_W-1:0] CSR_QUERY_ID   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUERY_TYPE = 1'b1;

   localparam logic [STEP_W-1:0] HDR_LAST = 4'd11;
   localparam logic [STEP_W-1:0] TRL_LAST = 4'd4;

   typedef struct packed {
      logic              hdr;
      logic              trl;
      logic              trunc;
      logic [FILL_W-1:0] len;
   } dqmb_cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_HDR,
      BK_LEN,
      BK_CHAR,
      BK_TRL
   } back_state_type;

endpackage

`default_nettype wire

FILE: rtl/dqmb_ram.sv
// ----------------------------------------------------------------------------
// dqmb_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module dqmb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/dqmb_fifo.sv
// ----------------------------------------------------------------------------
// dqmb_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module dqmb_fifo
   import dqmb_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire dqmb_cmd_type push_data,
   output logic              not_full,
   input  wire logic         pop,
   output dqmb_cmd_type      pop_data,
   output logic              not_empty
);

   dqmb_cmd_type       entry_ff [CMD_QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign not_full  = (count_ff != QCNT_W'(CMD_QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/dqmb_front.sv
// ----------------------------------------------------------------------------
// dqmb_front
// accepts name characters, buffers labels and issues emit commands
// ----------------------------------------------------------------------------
`default_nettype none

module dqmb_front
   import dqmb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [BYTE_W-1:0] req_name_char,
   input  wire logic              req_name_last,
   output logic                   cmd_push,
   output dqmb_cmd_type           cmd_data,
   input  wire logic              cmd_not_full,
   input  wire logic              flush_done,
   output logic                   ram_wr_en,
   output logic      [IDX_W-1:0]  ram_wr_addr,
   output logic      [BYTE_W-1:0] ram_wr_data
);

   logic              started_ff, started_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              trunc_ff, trunc_in;
   logic              busy_ff, busy_in;

   logic              accept;
   logic              is_dot;
   logic              room;
   logic [FILL_W-1:0] fill_after;
   logic              trunc_after;

   assign req_ready = cmd_not_full && !busy_ff;
   assign accept    = req_valid && req_ready;
   assign is_dot    = (req_name_char == DOT_CHAR);
   assign room      = (fill_ff < FILL_W'(MAX_LABEL));

   assign ram_wr_en   = accept && !is_dot && room;
   assign ram_wr_addr = fill_ff[IDX_W-1:0];
   assign ram_wr_data = req_name_char;

   always_comb begin
      fill_after  = (!is_dot && room) ? fill_ff + 1'b1 : fill_ff;
      trunc_after = trunc_ff || (!is_dot && !room);

      cmd_data.hdr   = !started_ff;
      cmd_data.trl   = req_name_last;
      cmd_data.trunc = trunc_after;
      if (is_dot) begin
         cmd_data.len = fill_ff;
      end else if (req_name_last) begin
         cmd_data.len = fill_after;
      end else begin
         cmd_data.len = '0;
      end
      cmd_push = accept && (cmd_data.hdr || cmd_data.trl || (cmd_data.len != '0));

      started_in = started_ff;
      fill_in    = fill_ff;
      trunc_in   = trunc_ff;
      busy_in    = busy_ff && !flush_done;
      if (accept) begin
         started_in = !req_name_last;
         fill_in    = (is_dot || req_name_last) ? '0 : fill_after;
         trunc_in   = req_name_last ? 1'b0 : trunc_after;
         busy_in    = (cmd_data.len != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         fill_ff    <= '0;
         trunc_ff   <= 1'b0;
         busy_ff    <= 1'b0;
      end else begin
         started_ff <= started_in;
         fill_ff    <= fill_in;
         trunc_ff   <= trunc_in;
         busy_ff    <= busy_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/dqmb_back.sv
// ----------------------------------------------------------------------------
// dqmb_back
// byte sequencer: header, label flush and question trailer into output register
// ----------------------------------------------------------------------------
`default_nettype none

module dqmb_back
   import dqmb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire dqmb_cmd_type      cmd_data,
   output logic                   cmd_pop,
   input  wire logic [WORD_W-1:0] query_id,
   input  wire logic [WORD_W-1:0] query_type,
   output logic      [IDX_W-1:0]  ram_rd_addr,
   input  wire logic [BYTE_W-1:0] ram_rd_data,
   output logic                   flush_done,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic      [BYTE_W-1:0] rsp_wire_byte,
   output logic                   rsp_run_last,
   output logic                   rsp_message_end,
   output logic                   rsp_label_truncated,
   output logic      [CNT_W-1:0]  rsp_message_length
);

   back_state_type    state_ff, state_in;
   dqmb_cmd_type      cmd_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [FILL_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic              valid_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic              run_last_ff, end_ff, trunc_ff;
   logic [CNT_W-1:0]  length_ff;

   logic              load;
   logic              emit;
   logic [BYTE_W-1:0] emit_byte;
   logic              emit_run_last;
   logic              emit_end;
   logic              last_char;
   logic [CNT_W-1:0]  cnt_plus;

   assign load      = !valid_ff || rsp_ready;
   assign last_char = (idx_ff == cmd_ff.len - 1'b1);
   assign cnt_plus  = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               if (cmd_data.hdr) begin
                  state_in = BK_HDR;
               end else if (cmd_data.len != '0) begin
                  state_in = BK_LEN;
               end else begin
                  state_in = BK_TRL;
               end
            end
         end
         BK_HDR: begin
            if (load && step_ff == HDR_LAST) begin
               if (cmd_ff.len != '0) begin
                  state_in = BK_LEN;
               end else if (cmd_ff.trl) begin
                  state_in = BK_TRL;
               end else begin
                  state_in = BK_IDLE;
               end
            end
         end
         BK_LEN: begin
            if (load) begin
               state_in = BK_CHAR;
            end
         end
         BK_CHAR: begin
            if (load && last_char) begin
               state_in = cmd_ff.trl ? BK_TRL : BK_IDLE;
            end
         end
         BK_TRL: begin
            if (load && step_ff == TRL_LAST) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd_pop       = 1'b0;
      emit          = 1'b0;
      emit_byte     = ZERO_BYTE;
      emit_run_last = 1'b0;
      emit_end      = 1'b0;
      flush_done    = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            cmd_pop = cmd_valid;
         end
         BK_HDR: begin
            emit = load;
            case (step_ff)
               4'd0:    emit_byte = query_id[15:8];
               4'd1:    emit_byte = query_id[7:0];
               4'd2:    emit_byte = FLAGS_RD[15:8];
               4'd3:    emit_byte = FLAGS_RD[7:0];
               4'd4:    emit_byte = QDCOUNT[15:8];
               4'd5:    emit_byte = QDCOUNT[7:0];
               default: emit_byte = ZERO_BYTE;
            endcase
            emit_run_last = (step_ff == HDR_LAST) && (cmd_ff.len == '0) && !cmd_ff.trl;
         end
         BK_LEN: begin
            emit      = load;
            emit_byte = BYTE_W'(cmd_ff.len);
         end
         BK_CHAR: begin
            emit          = load;
            emit_byte     = ram_rd_data;
            emit_run_last = last_char && !cmd_ff.trl;
            flush_done    = load && last_char;
         end
         BK_TRL: begin
            emit = load;
            case (step_ff)
               4'd1:    emit_byte = query_type[15:8];
               4'd2:    emit_byte = query_type[7:0];
               4'd3:    emit_byte = CLASS_IN[15:8];
               4'd4:    emit_byte = CLASS_IN[7:0];
               default: emit_byte = ZERO_BYTE;
            endcase
            emit_run_last = (step_ff == TRL_LAST);
            emit_end      = (step_ff == TRL_LAST);
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      step_in = (state_in != state_ff) ? '0 : (emit ? step_ff + 1'b1 : step_ff);
      if (state_ff == BK_CHAR) begin
         idx_in = emit ? idx_ff + 1'b1 : idx_ff;
      end else begin
         idx_in = '0;
      end
      // read address runs one step ahead so data lines up with idx_ff
      ram_rd_addr = idx_in[IDX_W-1:0];
      cnt_in      = cnt_ff;
      if (emit) begin
         cnt_in = emit_end ? '0 : cnt_plus;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         step_ff  <= '0;
         idx_ff   <= '0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
         if (emit) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff <= cmd_data;
      end
      if (emit) begin
         byte_ff     <= emit_byte;
         run_last_ff <= emit_run_last;
         end_ff      <= emit_end;
         trunc_ff    <= cmd_ff.trunc;
         length_ff   <= cnt_plus;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_wire_byte       = byte_ff;
   assign rsp_run_last        = run_last_ff;
   assign rsp_message_end     = end_ff;
   assign rsp_label_truncated = trunc_ff;
   assign rsp_message_length  = length_ff;

endmodule

`default_nettype wire

FILE: rtl/dns_query_message_builder.sv
// ----------------------------------------------------------------------------
// dns_query_message_builder
// turns a dotted domain name, one character per transfer, into a query message
//
// req_ channel: one name character per transfer, req_name_last on the final one.
// rsp_ channel: one message byte per transfer in wire order; rsp_run_last marks
// the last byte caused by a character, rsp_message_end the final class byte.
// csr_ channel: index 0 writes the query id, index 1 the question type; always
// ready; the user must see that they are written only while no message is in
// progress, as the block itself does not enforce it. The front buffers label
// characters in a small ram and queues commands; the back sequencer emits
// header, label and trailer bytes through an output register, one byte per
// cycle while rsp_ready stays high, and takes each command from the queue in
// its idle state, where it emits no byte. With the back idle, a transfer's
// command passes the queue and the idle state before its first byte is loaded
// into the output register. A character that causes no bytes does not drop
// req_ready by itself; while a label is flushed out of the ram it stays low.
// A stalled receiver holds the output register and backs the sequencer, the
// command queue and then req_ready up in turn. Reset empties the queue, drops
// any partial name and restores the registers to id 0x0404 and type 1.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_query_message_builder
   import dqmb_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [BYTE_W-1:0]      req_name_char,
   input  wire logic                   req_name_last,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic      [BYTE_W-1:0]      rsp_wire_byte,
   output logic                        rsp_run_last,
   output logic                        rsp_message_end,
   output logic                        rsp_label_truncated,
   output logic      [CNT_W-1:0]       rsp_message_length,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]      csr_data
);

   logic [WORD_W-1:0] query_id_ff, query_id_in;
   logic [WORD_W-1:0] query_type_ff, query_type_in;

   logic              cmd_push;
   dqmb_cmd_type      cmd_push_data;
   logic              cmd_not_full;
   logic              cmd_pop;
   dqmb_cmd_type      cmd_pop_data;
   logic              cmd_not_empty;
   logic              flush_done;
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [BYTE_W-1:0] ram_wr_data;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      query_id_in   = query_id_ff;
      query_type_in = query_type_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_QUERY_ID:   query_id_in   = csr_data;
            CSR_QUERY_TYPE: query_type_in = csr_data;
            default:        query_id_in   = query_id_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_id_ff   <= QUERY_ID_RESET;
         query_type_ff <= QUERY_TYPE_RESET;
      end else begin
         query_id_ff   <= query_id_in;
         query_type_ff <= query_type_in;
      end
   end

   dqmb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_name_char (req_name_char),
      .req_name_last (req_name_last),
      .cmd_push      (cmd_push),
      .cmd_data      (cmd_push_data),
      .cmd_not_full  (cmd_not_full),
      .flush_done    (flush_done),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data)
   );

   dqmb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_LABEL)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   dqmb_fifo u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .not_full  (cmd_not_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_pop_data),
      .not_empty (cmd_not_empty)
   );

   dqmb_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cmd_valid           (cmd_not_empty),
      .cmd_data            (cmd_pop_data),
      .cmd_pop             (cmd_pop),
      .query_id            (query_id_ff),
      .query_type          (query_type_ff),
      .ram_rd_addr         (ram_rd_addr),
      .ram_rd_data         (ram_rd_data),
      .flush_done          (flush_done),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_wire_byte       (rsp_wire_byte),
      .rsp_run_last        (rsp_run_last),
      .rsp_message_end     (rsp_message_end),
      .rsp_label_truncated (rsp_label_truncated),
      .rsp_message_length  (rsp_message_length)
   );

`ifndef NO_ASSERTIONS
   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_end |-> rsp_run_last)
      else $error("message end without run last");

   a_min_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_end |-> rsp_message_length >= 9'd17)
      else $error("message shorter than header and trailer");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> cmd_not_full)
      else $error("command pushed into full queue");

   a_no_write_in_flush: assert property (@(posedge clock) disable iff (reset)
      flush_done |-> !ram_wr_en)
      else $error("label ram written during flush");
`endif

endmodule

`default_nettype wire

FILE: verif/dns_query_message_builder_test.sv
// ----------------------------------------------------------------------------
// dns_query_message_builder_test
// self-checking bench for the query builder: a queue-fed driver sends name
// characters, a built-in predictor works out every message byte, and a monitor
// compares each rsp_ transfer field by field, under several pacing phases,
// register settings and one long receiver hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dns_query_message_builder_test
   import dqmb_pkg::*;
();

   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PHASE_ITEMS    = 72;
   localparam int LONG_LABELS    = 3;

   typedef struct packed {
      logic [BYTE_W-1:0] ch;
      logic              last;
   } name_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] wire_byte;
      logic              run_last;
      logic              message_end;
      logic              label_truncated;
      logic [CNT_W-1:0]  message_length;
   } query_byte_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [BYTE_W-1:0]      req_name_char = '0;
   logic                   req_name_last = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [BYTE_W-1:0]      rsp_wire_byte;
   logic                   rsp_run_last;
   logic                   rsp_message_end;
   logic                   rsp_label_truncated;
   logic [CNT_W-1:0]       rsp_message_length;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]      csr_data = '0;

   // stimulus and pacing
   name_item_type name_chars_pending[$];
   name_item_type next_item;
   int          items_queued = 0;
   int          items_accepted = 0;
   int          req_idle_pct = 0;
   int          rsp_stall_pct = 0;
   logic        hold_armed = 1'b0;
   logic        hold_taken = 1'b0;
   int          hold_left = 0;
   int          quiet_cycles = 0;
   int          failures = 0;

   // predictor state
   logic [WORD_W-1:0] query_id_cfg = QUERY_ID_RESET;
   logic [WORD_W-1:0] query_type_cfg = QUERY_TYPE_RESET;
   logic              name_open;
   logic [BYTE_W-1:0] label_buf [MAX_LABEL];
   int                label_count;
   logic              trunc_flag;
   logic [CNT_W-1:0]  byte_count;
   query_byte_type    step_bytes [64];
   int                step_len;
   query_byte_type    query_bytes_due[$];
   query_byte_type    due_byte;

   dns_query_message_builder dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_name_char       (req_name_char),
      .req_name_last       (req_name_last),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_wire_byte       (rsp_wire_byte),
      .rsp_run_last        (rsp_run_last),
      .rsp_message_end     (rsp_message_end),
      .rsp_label_truncated (rsp_label_truncated),
      .rsp_message_length  (rsp_message_length),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   task automatic append_byte(input logic [BYTE_W-1:0] b);
      if (byte_count < CNT_MAX) byte_count = byte_count + 1'b1;
      step_bytes[step_len] = '{wire_byte: b, run_last: 1'b0, message_end: 1'b0,
                               label_truncated: trunc_flag, message_length: byte_count};
      step_len++;
   endtask

   task automatic flush_label();
      if (label_count != 0) begin
         append_byte(BYTE_W'(label_count));
         for (int i = 0; i < label_count; i++) append_byte(label_buf[i]);
         label_count = 0;
      end
   endtask

   task automatic predict_query_bytes(input logic [BYTE_W-1:0] ch, input logic last);
      step_len = 0;
      if (!name_open) begin
         name_open = 1'b1;
         append_byte(query_id_cfg[15:8]);
         append_byte(query_id_cfg[7:0]);
         append_byte(FLAGS_RD[15:8]);
         append_byte(FLAGS_RD[7:0]);
         append_byte(QDCOUNT[15:8]);
         append_byte(QDCOUNT[7:0]);
         repeat (6) append_byte(ZERO_BYTE);
      end
      if (ch == DOT_CHAR) begin
         flush_label();
      end else if (label_count < MAX_LABEL) begin
         label_buf[label_count] = ch;
         label_count++;
      end else begin
         trunc_flag = 1'b1;
      end
      if (last) begin
         flush_label();
         append_byte(ZERO_BYTE);
         append_byte(query_type_cfg[15:8]);
         append_byte(query_type_cfg[7:0]);
         append_byte(CLASS_IN[15:8]);
         append_byte(CLASS_IN[7:0]);
         step_bytes[step_len-1].message_end = 1'b1;
         name_open = 1'b0;
         label_count = 0;
         trunc_flag = 1'b0;
         byte_count = '0;
      end
      if (step_len > 0) step_bytes[step_len-1].run_last = 1'b1;
      for (int i = 0; i < step_len; i++) query_bytes_due.push_back(step_bytes[i]);
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (name_chars_pending.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            next_item = name_chars_pending.pop_front();
            req_valid <= 1'b1;
            req_name_char <= next_item.ch;
            req_name_last <= next_item.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver with an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_taken <= 1'b0;
      end else if (hold_armed && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (reset) begin
         name_open <= 1'b0;
         label_count <= 0;
         trunc_flag <= 1'b0;
         byte_count <= '0;
      end else begin
         if (req_valid && req_ready) begin
            predict_query_bytes(req_name_char, req_name_last);
            items_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (query_bytes_due.size() == 0) begin
               $error("unexpected transfer: wire_byte %0h", rsp_wire_byte);
               failures++;
            end else begin
               due_byte = query_bytes_due.pop_front();
               if (rsp_wire_byte !== due_byte.wire_byte) begin
                  $error("wire_byte: expected %0h, got %0h", due_byte.wire_byte, rsp_wire_byte);
                  failures++;
               end
               if (rsp_run_last !== due_byte.run_last) begin
                  $error("run_last: expected %0d, got %0d", due_byte.run_last, rsp_run_last);
                  failures++;
               end
               if (rsp_message_end !== due_byte.message_end) begin
                  $error("message_end: expected %0d, got %0d",
                         due_byte.message_end, rsp_message_end);
                  failures++;
               end
               if (rsp_label_truncated !== due_byte.label_truncated) begin
                  $error("label_truncated: expected %0d, got %0d",
                         due_byte.label_truncated, rsp_label_truncated);
                  failures++;
               end
               if (rsp_message_length !== due_byte.message_length) begin
                  $error("message_length: expected %0d, got %0d",
                         due_byte.message_length, rsp_message_length);
                  failures++;
               end
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic push_char(input logic [BYTE_W-1:0] ch, input logic last);
      name_chars_pending.push_back('{ch: ch, last: last});
      items_queued++;
   endtask

   function automatic logic [BYTE_W-1:0] random_label_char();
      logic [BYTE_W-1:0] c;
      if ($urandom_range(3) != 0) c = BYTE_W'(8'h61 + $urandom_range(25));
      else c = BYTE_W'($urandom_range(255));
      if (c == DOT_CHAR) c = 8'h2d;
      return c;
   endfunction

   task automatic queue_random_names(input int target);
      int                stop_at;
      int                n_labels;
      int                len;
      logic [BYTE_W-1:0] chars[$];
      stop_at = items_queued + target;
      while (items_queued < stop_at) begin
         chars.delete();
         if ($urandom_range(4) == 0) begin
            // noise: loose characters, dots and name ends
            repeat ($urandom_range(1, 12))
               push_char(($urandom_range(3) == 0) ? DOT_CHAR : BYTE_W'($urandom_range(255)),
                         $urandom_range(9) == 0);
         end else begin
            if ($urandom_range(7) == 0) chars.push_back(DOT_CHAR);
            n_labels = $urandom_range(1, 4);
            for (int l = 0; l < n_labels; l++) begin
               if ($urandom_range(11) == 0) len = $urandom_range(MAX_LABEL - 2, MAX_LABEL + 6);
               else len = $urandom_range(0, 6);
               repeat (len) chars.push_back(random_label_char());
               if (l < n_labels - 1 || $urandom_range(4) == 0) chars.push_back(DOT_CHAR);
            end
            if (chars.size() == 0) chars.push_back(DOT_CHAR);
            foreach (chars[i]) push_char(chars[i], i == chars.size() - 1);
         end
      end
      push_char(8'h7a, 1'b1);
   endtask

   task automatic wait_for_idle();
      do @(posedge clock);
      while (items_accepted != items_queued || query_bytes_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [WORD_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_QUERY_ID) query_id_cfg = value;
      else query_type_cfg = value;
   endtask

   task automatic set_pacing(input int req_pct, input int rsp_pct);
      req_idle_pct <= req_pct;
      rsp_stall_pct <= rsp_pct;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed names with reset register values
      set_pacing(0, 0);
      push_char(8'h61, 1'b1);
      push_char(DOT_CHAR, 1'b1);
      push_char(DOT_CHAR, 1'b0);
      push_char(DOT_CHAR, 1'b0);
      push_char(DOT_CHAR, 1'b1);
      push_char(8'h00, 1'b0);
      push_char(8'hff, 1'b0);
      push_char(DOT_CHAR, 1'b0);
      push_char(8'h7f, 1'b0);
      push_char(8'h80, 1'b1);
      push_char(DOT_CHAR, 1'b0);
      push_char(8'h61, 1'b0);
      push_char(8'h62, 1'b0);
      push_char(DOT_CHAR, 1'b0);
      push_char(DOT_CHAR, 1'b0);
      push_char(8'h63, 1'b0);
      push_char(DOT_CHAR, 1'b1);
      push_char(8'h78, 1'b0);
      push_char(8'h79, 1'b1);
      wait_for_idle();

      write_register(CSR_QUERY_ID, 16'hffff);
      write_register(CSR_QUERY_TYPE, 16'h0000);
      set_pacing(0, 0);
      queue_random_names(PHASE_ITEMS);
      wait_for_idle();

      write_register(CSR_QUERY_ID, 16'h0000);
      write_register(CSR_QUERY_TYPE, 16'hffff);
      set_pacing(63, 0);
      queue_random_names(PHASE_ITEMS);
      wait_for_idle();

      write_register(CSR_QUERY_ID, WORD_W'($urandom_range(65535)));
      write_register(CSR_QUERY_TYPE, WORD_W'($urandom_range(65535)));
      set_pacing(0, 63);
      queue_random_names(PHASE_ITEMS);
      wait_for_idle();

      write_register(CSR_QUERY_ID, WORD_W'($urandom_range(65535)));
      write_register(CSR_QUERY_TYPE, WORD_W'($urandom_range(65535)));
      set_pacing(14, 14);
      queue_random_names(PHASE_ITEMS);
      wait_for_idle();

      // long hold-off on the receiver while a very long name streams in
      write_register(CSR_QUERY_ID, WORD_W'($urandom_range(65535)));
      write_register(CSR_QUERY_TYPE, 16'h001c);
      set_pacing(0, 20);
      hold_armed <= 1'b1;
      for (int l = 0; l < LONG_LABELS; l++) begin
         repeat (MAX_LABEL + 1) push_char(random_label_char(), 1'b0);
         push_char(DOT_CHAR, l == LONG_LABELS - 1);
      end
      queue_random_names(PHASE_ITEMS / 2);
      wait_for_idle();

      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
